/* hw/rtl/lkc_pkg.sv */
// Shared constants and types for the LRU key cache.
`timescale 1ns / 1ps

package lkc_pkg;

  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  // Result flags, hit in the lowest bit.
  typedef struct packed {
    logic evicted_valid;
    logic hit;
  } lkc_flags_t;

endpackage

/* hw/rtl/lru_key_cache_core.sv */
// Top level of the LRU key cache: row of key cells, occupancy control, result buffer.
// The result of a key is registered in the result buffer before it appears on out_*.
// Throughput: one key per cycle while in_tready is high; the whole cell row compares and shifts at once.
// The two-entry result buffer keeps accepting while one result waits downstream.
// Reset (rst_n low, synchronous): cache empty, capacity 16 (ENTRIES if smaller), result buffer empty.
// Stored keys are not cleared; no clearing pass is needed.
`timescale 1ns / 1ps

module lru_key_cache_core
  import lkc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16,
  localparam int OCC_W   = $clog2(ENTRIES + 1),
  localparam int IN_W    = ((KEY_BITS + 7) / 8) * 8,
  localparam int OUT_W   = ((KEY_BITS + OCC_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // key
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // evicted_key, occupancy
  output logic [1:0]       out_tuser,  // hit, evicted_valid
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data    // capacity
);

  localparam int RES_W     = KEY_BITS + OCC_W;
  localparam int LIM_RESET = (ENTRIES < CAP_RESET) ? ENTRIES : CAP_RESET;

  logic [OCC_W-1:0]    fill_r, fill_nxt;
  logic [OCC_W-1:0]    lim_r, lim_nxt;
  logic [KEY_BITS-1:0] in_key;
  logic                acc, cfg_wr, full, hit, ev_valid;
  logic [OCC_W-1:0]    hit_pos, bound, last, occ_step;
  logic [KEY_BITS-1:0] evk_any, evk_out;
  logic [ENTRIES-1:0]  match_vec;
  logic [KEY_BITS-1:0] cell_key   [ENTRIES];
  logic [KEY_BITS-1:0] cell_evict [ENTRIES];
  lkc_flags_t          res_flags, out_flags;
  logic [RES_W-1:0]    res_data, out_data;

  assign in_key    = in_tdata[KEY_BITS-1:0];
  assign acc       = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign full = (fill_r == lim_r);
  assign last = lim_r - OCC_W'(1);

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic [KEY_BITS-1:0] left_key;
      if (g == 0) begin : g_head
        assign left_key = in_key;
      end else begin : g_body
        assign left_key = cell_key[g-1];
      end
      lkc_cell #(
        .KEY_BITS (KEY_BITS),
        .OCC_W    (OCC_W),
        .IDX      (g)
      ) u_cell (
        .clk       (clk),
        .load      (acc),
        .probe     (in_key),
        .left_key  (left_key),
        .fill      (fill_r),
        .bound     (bound),
        .last      (last),
        .key       (cell_key[g]),
        .match     (match_vec[g]),
        .evict_key (cell_evict[g])
      );
    end
  endgenerate

  // Keys are unique among held cells, so OR-ing match indexes acts as a select; only the last cell drives evict keys.
  always_comb begin
    hit_pos = '0;
    evk_any = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (match_vec[j]) begin
        hit_pos = hit_pos | OCC_W'(j);
      end
      evk_any = evk_any | cell_evict[j];
    end
  end

  assign hit      = |match_vec;
  assign ev_valid = !hit && full;
  assign evk_out  = ev_valid ? evk_any : '0;

  always_comb begin
    priority if (hit) begin
      bound = hit_pos;
    end else if (full) begin
      bound = fill_r - OCC_W'(1);
    end else begin
      bound = fill_r;
    end
  end

  assign occ_step = (!hit && !full) ? fill_r + OCC_W'(1) : fill_r;

  always_comb begin
    fill_nxt = fill_r;
    lim_nxt  = lim_r;
    if (cfg_wr) begin
      // writing capacity empties the store
      fill_nxt = '0;
      if (cfg_data == '0) begin
        lim_nxt = OCC_W'(1);
      end else if (int'(cfg_data) > ENTRIES) begin
        lim_nxt = OCC_W'(ENTRIES);
      end else begin
        lim_nxt = OCC_W'(cfg_data);
      end
    end else if (acc) begin
      fill_nxt = occ_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      lim_r  <= OCC_W'(LIM_RESET);
    end else begin
      fill_r <= fill_nxt;
      lim_r  <= lim_nxt;
    end
  end

  assign res_flags.hit           = hit;
  assign res_flags.evicted_valid = ev_valid;
  assign res_data                = {occ_step, evk_out};

  lkc_outbuf #(
    .DATA_W (RES_W)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_flags  (res_flags),
    .in_data   (res_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_flags (out_flags),
    .out_data  (out_data)
  );

  assign out_tuser = out_flags;

  always_comb begin
    out_tdata              = '0;
    out_tdata[RES_W-1:0]   = out_data;
  end

`ifndef SYNTHESIS
  a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lim_r)
    else $error("occupancy above capacity limit");

  a_unique_match : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key held in more than one cell");

  a_miss_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_wr && !hit && !full) |=> (fill_r == $past(fill_r) + OCC_W'(1)))
    else $error("miss with free room did not grow occupancy");

  a_hit_keeps : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_wr && hit) |=> (fill_r == $past(fill_r)))
    else $error("hit changed occupancy");

  a_front_key : assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (cell_key[0] == $past(in_key)))
    else $error("accepted key not at most-recent position");
`endif

endmodule

/* hw/rtl/lkc_cell.sv */
// One cell of the recency-ordered key row: holds one key, compares it, shifts right.
`timescale 1ns / 1ps

module lkc_cell #(
  parameter int KEY_BITS = 16,
  parameter int OCC_W    = 5,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                load,
  input  logic [KEY_BITS-1:0] probe,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [OCC_W-1:0]    fill,
  input  logic [OCC_W-1:0]    bound,
  input  logic [OCC_W-1:0]    last,
  output logic [KEY_BITS-1:0] key,
  output logic                match,
  output logic [KEY_BITS-1:0] evict_key
);

  localparam logic [OCC_W-1:0] POS = OCC_W'(IDX);

  logic [KEY_BITS-1:0] key_r;

  // On load, take the neighbor's key when this position lies at or before the shift bound.
  always_ff @(posedge clk) begin
    if (load && (POS <= bound)) begin
      key_r <= left_key;
    end
  end

  assign key       = key_r;
  assign match     = (POS < fill) && (key_r == probe);
  assign evict_key = (POS == last) ? key_r : '0;

endmodule

/* hw/rtl/lkc_outbuf.sv */
// Two-entry output buffer (main register plus skid) for the result stream.
`timescale 1ns / 1ps

module lkc_outbuf
  import lkc_pkg::*;
#(
  parameter int DATA_W = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lkc_flags_t        in_flags,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lkc_flags_t        out_flags,
  output logic [DATA_W-1:0] out_data
);

  logic              main_v_r, main_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  lkc_flags_t        main_flags_r, skid_flags_r;
  logic [DATA_W-1:0] main_data_r, skid_data_r;
  logic              push, pop;
  logic              main_from_in, main_from_skid, skid_from_in;

  assign in_ready = !skid_v_r;
  assign push     = in_valid && in_ready;
  assign pop      = main_v_r && out_ready;

  always_comb begin
    main_v_nxt     = main_v_r;
    skid_v_nxt     = skid_v_r;
    main_from_in   = 1'b0;
    main_from_skid = 1'b0;
    skid_from_in   = 1'b0;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        // advance skid into main, new transfer lands in skid
        main_v_nxt     = 1'b1;
        main_from_skid = 1'b1;
        skid_v_nxt     = push;
        skid_from_in   = push;
      end else begin
        main_v_nxt   = push;
        main_from_in = push;
      end
    end else if (push) begin
      skid_v_nxt   = 1'b1;
      skid_from_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (main_from_skid) begin
      main_flags_r <= skid_flags_r;
      main_data_r  <= skid_data_r;
    end else if (main_from_in) begin
      main_flags_r <= in_flags;
      main_data_r  <= in_data;
    end
    if (skid_from_in) begin
      skid_flags_r <= in_flags;
      skid_data_r  <= in_data;
    end
  end

  assign out_valid = main_v_r;
  assign out_flags = main_flags_r;
  assign out_data  = main_data_r;

endmodule
